FILE: sv/spq_pkg.sv
// shared types and constants for the stable priority queue
package spq_pkg;

  localparam int PRIORITY_BITS   = 8;
  localparam int PAYLOAD_BITS    = 16;
  localparam int STATUS_BITS     = 2;
  localparam int OCC_BITS        = 5;
  localparam int QUEUE_DEPTH_DEF = 16;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     req_type;
    logic [PRIORITY_BITS-1:0] entry_priority;
    logic [PAYLOAD_BITS-1:0]  entry_payload;
  } spq_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [PAYLOAD_BITS-1:0]  popped_payload;
    logic [PRIORITY_BITS-1:0] popped_priority;
    logic                     head_valid;
    logic [PAYLOAD_BITS-1:0]  head_payload;
    logic [OCC_BITS-1:0]      occupancy;
  } spq_result_t;

  // contents of one slot of the sorted row
  typedef struct packed {
    logic                     valid;
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
  } spq_entry_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD = 2'b00,
    CELL_PUSH = 2'b01,
    CELL_POP  = 2'b10
  } spq_cell_op_t;

endpackage

FILE: sv/spq_cell.sv
// one slot of the sorted row: compare against the new entry and shift
module spq_cell
  import spq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  spq_cell_op_t op,
  input  spq_entry_t   new_entry,
  input  spq_entry_t   left_entry,
  input  logic         left_keep,
  input  spq_entry_t   right_entry,
  output spq_entry_t   entry,
  output logic         keep
);

  spq_entry_t entry_next;

  // entry stays in place on push when it ranks at or above the new one
  assign keep = entry.valid && (entry.prio >= new_entry.prio);

  // select from self, new entry, left or right neighbor
  always_comb begin
    entry_next = entry;
    case (op)
      CELL_PUSH: begin
        if (keep) begin
          entry_next = entry;
        end else if (left_keep) begin
          entry_next = new_entry;
        end else begin
          entry_next = left_entry;
        end
      end
      CELL_POP:  entry_next = right_entry;
      CELL_HOLD: entry_next = entry;
      default:   entry_next = entry;
    endcase
  end

  // valid bit under reset, data without
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.prio    <= entry_next.prio;
    entry.payload <= entry_next.payload;
  end

endmodule

FILE: sv/stable_priority_queue_unit.sv
// top level of the stable priority queue: row of compare-and-shift cells
//
// Bounded priority queue held in a row of QUEUE_DEPTH cells, highest priority in the head cell,
// equal priorities in arrival order. One push or pop is taken every clock cycle: busy stays low,
// and each cell compares itself with the pushed entry and shifts toward its neighbor in the same
// cycle. The result of a request accepted at one edge is shown for exactly one cycle after it,
// marked by done; the receiver cannot stall, so it must sample the result in that cycle. head
// and occupancy in a result give the queue after that request. A push to a full queue returns
// status full and a pop on an empty queue status empty, both leaving the queue unchanged.
module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  spq_req_t    req,
  output logic        done,
  output spq_result_t result
);

  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  spq_entry_t   cell_entry [QUEUE_DEPTH];
  logic         cell_keep  [QUEUE_DEPTH];
  spq_entry_t   new_entry;
  spq_entry_t   empty_entry;
  spq_cell_op_t op;
  logic         accept;
  logic         full;
  logic         empty;
  logic         push_ok;
  logic         pop_ok;

  logic [CountW-1:0]        count;
  logic [STATUS_BITS-1:0]   status;
  logic [PAYLOAD_BITS-1:0]  popped_payload;
  logic [PRIORITY_BITS-1:0] popped_priority;

  // one request per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CountW'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  assign push_ok = accept && (req.req_type == REQ_PUSH) && !full;
  assign pop_ok  = accept && (req.req_type == REQ_POP) && !empty;

  assign new_entry   = '{valid: 1'b1, prio: req.entry_priority, payload: req.entry_payload};
  assign empty_entry = '0;

  // operation to the row
  always_comb begin
    if (push_ok) begin
      op = CELL_PUSH;
    end else if (pop_ok) begin
      op = CELL_POP;
    end else begin
      op = CELL_HOLD;
    end
  end

  // row of cells, head at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_entry_t left_e;
    spq_entry_t right_e;
    logic       left_k;

    if (i == 0) begin : g_head
      assign left_e = empty_entry;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_k = cell_keep[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = empty_entry;
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  // occupancy counter and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= accept;
      if (push_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  // result fields captured with the transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.req_type == REQ_PUSH) begin
        status <= full ? ST_FULL : ST_OK;
      end else begin
        status <= empty ? ST_EMPTY : ST_OK;
      end
      popped_payload  <= pop_ok ? cell_entry[0].payload : '0;
      popped_priority <= pop_ok ? cell_entry[0].prio : '0;
    end
  end

  // head comes straight from the updated head cell
  always_comb begin
    result.status          = status;
    result.popped_payload  = popped_payload;
    result.popped_priority = popped_priority;
    result.head_valid      = cell_entry[0].valid;
    result.head_payload    = cell_entry[0].valid ? cell_entry[0].payload : '0;
    result.occupancy       = OCC_BITS'(count);
  end

endmodule

FILE: sv/spq_checker.sv
// port-level checks for the stable priority queue, bound to the top level
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input spq_result_t result
);

  // every transfer gives exactly one result in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("missing result after request transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without request transfer");

  // head presence agrees with occupancy
  a_head_occ: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.head_valid == (result.occupancy != '0)))
    else $error("head valid disagrees with occupancy");

  // refused push only when full, empty pop only when empty
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (result.occupancy == OCC_BITS'(QUEUE_DEPTH)))
    else $error("full status while not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> (result.occupancy == '0 && !result.head_valid))
    else $error("empty status while entries stored");

endmodule

bind stable_priority_queue_unit spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
